@@ design/tal_pkg.sv @@
// shared types, constants and reset values of the tilt angle led bar
// no dependencies
package tal_pkg;

   localparam int EDGE_COUNT = 4;
   localparam int EDGE_IDX_W = $clog2(EDGE_COUNT);
   localparam int EDGE_W = 32;
   localparam int ACCEL_W = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int PROD_W = 2 * EDGE_W;

   typedef logic signed [ACCEL_W-1:0] accel_type;
   typedef logic [ACCEL_W-1:0] mag_type;
   typedef logic [EDGE_W-1:0] edge_type;
   typedef logic [EDGE_IDX_W-1:0] edge_idx_type;
   typedef logic [EDGE_COUNT-1:0][EDGE_W-1:0] edge_array_type;
   typedef logic [2:0] led_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      edge_type op_a;
      edge_type op_b;
   } mul_op_type;

   localparam csr_index_type CSR_EDGE_TAN_SQ_10 = 8'd0;
   localparam csr_index_type CSR_EDGE_TAN_SQ_20 = 8'd1;
   localparam csr_index_type CSR_EDGE_TAN_SQ_30 = 8'd2;
   localparam csr_index_type CSR_EDGE_TAN_SQ_40 = 8'd3;

   localparam edge_array_type EDGE_RESET = {
      32'd3024035749, 32'd1431655765, 32'd568972357, 32'd133535703
   };

   function automatic mag_type magnitude(input accel_type value);
      mag_type raw;
      raw = mag_type'(value);
      return raw[ACCEL_W-1] ? mag_type'(~raw + 1'b1) : raw;
   endfunction

endpackage

@@ design/tal_ifs.sv @@
// valid/ready channels of the tilt angle led bar: sample, result, register write
// depends on tal_pkg
interface tal_req_if;
   logic valid;
   logic ready;
   tal_pkg::accel_type accel_x;
   tal_pkg::accel_type accel_y;
   tal_pkg::accel_type accel_z;
   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tal_rsp_if;
   logic valid;
   logic ready;
   logic led_lit;
   tal_pkg::led_type led_index;
   logic in_range;
   modport source (output valid, led_lit, led_index, in_range, input ready);
   modport sink (input valid, led_lit, led_index, in_range, output ready);
endinterface

interface tal_csr_if;
   logic valid;
   logic ready;
   tal_pkg::csr_index_type index;
   tal_pkg::edge_type data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/tal_mul.sv @@
// shared 32x32 unsigned multiplier with registered product
// depends on tal_pkg
module tal_mul (
   input  logic                clock,
   input  tal_pkg::mul_op_type op,
   output tal_pkg::prod_type   prod_ff
);

   tal_pkg::prod_type prod_in;

   assign prod_in = tal_pkg::prod_type'(op.op_a) * tal_pkg::prod_type'(op.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ design/tal_seq.sv @@
// sequencer: squares, sum, edge products and compares on the shared multiplier,
// led state and result register; depends on tal_pkg and tal_ifs
module tal_seq (
   input  logic                    clock,
   input  logic                    reset,
   tal_req_if.sink                 req_if,
   tal_rsp_if.source               rsp_if,
   input  tal_pkg::edge_array_type edges,
   input  tal_pkg::prod_type       prod,
   output tal_pkg::mul_op_type     mul_op
);

   typedef enum logic [2:0] {
      S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SUM, S_EDGE, S_CMP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   tal_pkg::mag_type ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic xneg_ff, xneg_in;
   logic [30:0] lhs_ff, lhs_in;
   tal_pkg::edge_type den_ff, den_in;
   tal_pkg::edge_idx_type k_ff, k_in;
   logic hit_ff, hit_in;
   tal_pkg::led_type lit_led_ff, lit_led_in;
   logic any_lit_ff, any_lit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_lit_ff, rsp_lit_in;
   tal_pkg::led_type rsp_index_ff, rsp_index_in;
   logic rsp_range_ff, rsp_range_in;

   tal_pkg::edge_idx_type edge_sel;
   tal_pkg::edge_idx_type k_next;
   tal_pkg::prod_type lhs_full;
   logic hit_now;
   tal_pkg::led_type led_new;

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.led_lit = rsp_lit_ff;
   assign rsp_if.led_index = rsp_index_ff;
   assign rsp_if.in_range = rsp_range_ff;

   assign k_next = tal_pkg::edge_idx_type'(k_ff + 1'b1);
   assign edge_sel = (state_ff == S_EDGE) ? '0 : k_next;
   assign lhs_full = {1'b0, lhs_ff, 32'b0};
   assign hit_now = (lhs_full <= prod);
   assign led_new = xneg_ff ? {1'b1, k_ff} : {1'b0, ~k_ff};

   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         S_SQ_X: begin
            mul_op.op_a = tal_pkg::edge_type'(ax_ff);
            mul_op.op_b = tal_pkg::edge_type'(ax_ff);
         end
         S_SQ_Y: begin
            mul_op.op_a = tal_pkg::edge_type'(ay_ff);
            mul_op.op_b = tal_pkg::edge_type'(ay_ff);
         end
         S_SQ_Z: begin
            mul_op.op_a = tal_pkg::edge_type'(az_ff);
            mul_op.op_b = tal_pkg::edge_type'(az_ff);
         end
         S_EDGE, S_CMP: begin
            mul_op.op_a = edges[edge_sel];
            mul_op.op_b = den_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      az_in = az_ff;
      xneg_in = xneg_ff;
      lhs_in = lhs_ff;
      den_in = den_ff;
      k_in = k_ff;
      hit_in = hit_ff;
      lit_led_in = lit_led_ff;
      any_lit_in = any_lit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_lit_in = rsp_lit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_range_in = rsp_range_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               ax_in = tal_pkg::magnitude(req_if.accel_x);
               ay_in = tal_pkg::magnitude(req_if.accel_y);
               az_in = tal_pkg::magnitude(req_if.accel_z);
               xneg_in = req_if.accel_x[tal_pkg::ACCEL_W-1];
               k_in = '0;
               state_in = S_SQ_X;
            end
         end
         S_SQ_X: state_in = S_SQ_Y;
         S_SQ_Y: begin
            lhs_in = prod[30:0];
            state_in = S_SQ_Z;
         end
         S_SQ_Z: begin
            den_in = prod[31:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            den_in = den_ff + prod[31:0];
            state_in = S_EDGE;
         end
         S_EDGE: state_in = S_CMP;
         S_CMP: begin
            if (hit_now || k_ff == tal_pkg::edge_idx_type'(tal_pkg::EDGE_COUNT - 1)) begin
               hit_in = hit_now;
               state_in = S_DONE;
            end else begin
               k_in = k_next;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               if (hit_ff) begin
                  lit_led_in = led_new;
                  any_lit_in = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_lit_in = hit_ff || any_lit_ff;
               rsp_index_in = hit_ff ? led_new : lit_led_ff;
               rsp_range_in = hit_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lit_led_ff <= '0;
         any_lit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lit_led_ff <= lit_led_in;
         any_lit_ff <= any_lit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
      xneg_ff <= xneg_in;
      lhs_ff <= lhs_in;
      den_ff <= den_in;
      k_ff <= k_in;
      hit_ff <= hit_in;
      rsp_lit_ff <= rsp_lit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_range_ff <= rsp_range_in;
   end

endmodule

@@ design/tilt_angle_led_bar.sv @@
// tilt angle led bar top level: edge registers, sequencer and shared multiplier
// depends on tal_pkg, tal_ifs, tal_mul and tal_seq
//
// req_if takes one accelerometer item (accel_x, accel_y, accel_z) at a time.
// rsp_if returns one item per sample: led_lit, led_index and in_range.
// csr_if writes the four tan squared bin edges (index 0 to 3, Q0.32);
// other indexes are ignored. csr_if is always ready; it is to be written
// only while idle: the user must keep to this, the block does not enforce it.
// From req accept to rsp valid it computes three squares, one sum, then one
// edge product per bin tested, all on one shared 32x32 multiplier whose
// product is registered. The first matching bin ends the search. A new
// item is accepted the cycle after its result is loaded.
// The result sits in an output register; while the receiver stalls the next
// item is still accepted and computed, and waits only to load that register.
// Reset restores the edge defaults, clears the lit led state and the result
// valid.
module tilt_angle_led_bar (
   input  logic       clock,
   input  logic       reset,
   tal_req_if.sink    req_if,
   tal_rsp_if.source  rsp_if,
   tal_csr_if.sink    csr_if
);

   tal_pkg::edge_array_type edge_ff, edge_in;
   tal_pkg::mul_op_type mul_op;
   tal_pkg::prod_type prod;

   assign csr_if.ready = 1'b1;

   always_comb begin
      edge_in = edge_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            tal_pkg::CSR_EDGE_TAN_SQ_10: edge_in[0] = csr_if.data;
            tal_pkg::CSR_EDGE_TAN_SQ_20: edge_in[1] = csr_if.data;
            tal_pkg::CSR_EDGE_TAN_SQ_30: edge_in[2] = csr_if.data;
            tal_pkg::CSR_EDGE_TAN_SQ_40: edge_in[3] = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= tal_pkg::EDGE_RESET;
      end else begin
         edge_ff <= edge_in;
      end
   end

   tal_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .edges  (edge_ff),
      .prod   (prod),
      .mul_op (mul_op)
   );

   tal_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod)
   );

endmodule
